>>> sv/dmfp_pkg.sv
package dmfp_pkg;

  // parse phases of one framed message
  typedef enum logic [3:0] {
    PH_PREFIX = 4'd0,
    PH_HEADER = 4'd1,
    PH_NAME   = 4'd2,
    PH_QTYPE  = 4'd3,
    PH_QCLASS = 4'd4,
    PH_PTR    = 4'd5,
    PH_TYPE   = 4'd6,
    PH_CLASS  = 4'd7,
    PH_TTL    = 4'd8,
    PH_RDLEN  = 4'd9,
    PH_ADDR   = 4'd10,
    PH_IDLE   = 4'd11
  } phase_t;

  // result kinds
  typedef enum logic [3:0] {
    K_CHAR    = 4'd0,
    K_QTYPE   = 4'd1,
    K_QCLASS  = 4'd2,
    K_ANCOUNT = 4'd3,
    K_TYPE    = 4'd4,
    K_CLASS   = 4'd5,
    K_TTL     = 4'd6,
    K_RDLEN   = 4'd7,
    K_ADDR    = 4'd8,
    K_END     = 4'd9
  } kind_t;

  localparam int unsigned POS_W       = 17;
  localparam int unsigned ADDR_BYTES  = 16;
  localparam int unsigned ANC_HI_POS  = 8;
  localparam int unsigned ANC_LO_POS  = 9;
  localparam int unsigned LAST_HDR_POS = 13;
  localparam logic [7:0]  DOT_CHAR    = 8'h2e;
  localparam logic [15:0] WANTED_RST  = 16'd28;

  // result queue between parser and output stage
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        last;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

endpackage

>>> sv/dmfp_front.sv
module dmfp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [7:0]        in_byte,
  input  logic              in_mode,
  input  logic              q_full,
  input  logic              cfg_tvalid,
  input  logic [15:0]       cfg_value,
  output logic              in_tready,
  output dmfp_pkg::push_t   push
);

  logic [dmfp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]                len_r, len_nxt;
  dmfp_pkg::phase_t           phase_r, phase_nxt;
  logic [7:0]                 label_r, label_nxt;
  logic                       started_r, started_nxt;
  logic [31:0]                acc_r, acc_nxt;
  logic [2:0]                 cnt_r, cnt_nxt;
  logic [15:0]                ancount_r, ancount_nxt;
  logic                       mode_r, mode_nxt;
  logic [15:0]                wanted_r;

  logic                       accept;
  logic                       first;
  logic                       final_byte;
  logic [15:0]                len_cmp;
  logic [31:0]                acc_shift;
  logic [2:0]                 cnt_inc;
  logic                       field_done;
  logic                       have;
  dmfp_pkg::kind_t            kind;
  logic [31:0]                value;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // shared decode of the current byte
  assign first      = (phase_r == dmfp_pkg::PH_PREFIX) && (pos_r == '0);
  assign len_cmp    = (phase_r == dmfp_pkg::PH_PREFIX) ? (len_r | {8'h00, in_byte}) : len_r;
  assign final_byte = !first && (pos_r == ({1'b0, len_cmp} + 17'd1));
  assign acc_shift  = {acc_r[23:0], in_byte};
  assign cnt_inc    = cnt_r + 3'd1;
  assign field_done = (phase_r == dmfp_pkg::PH_TTL) ? (cnt_inc >= 3'd4) : (cnt_inc >= 3'd2);

  // next parse state
  always_comb begin
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    phase_nxt   = phase_r;
    label_nxt   = label_r;
    started_nxt = started_r;
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    ancount_nxt = ancount_r;
    mode_nxt    = mode_r;
    if (accept) begin
      unique case (phase_r)
        dmfp_pkg::PH_PREFIX: begin
          if (pos_r == '0) begin
            mode_nxt = in_mode;
            len_nxt  = {in_byte, 8'h00};
          end else begin
            len_nxt   = len_r | {8'h00, in_byte};
            phase_nxt = dmfp_pkg::PH_HEADER;
          end
        end
        dmfp_pkg::PH_HEADER: begin
          if (pos_r == 17'(dmfp_pkg::ANC_HI_POS)) begin
            acc_nxt = {24'h0, in_byte};
          end else if (pos_r == 17'(dmfp_pkg::ANC_LO_POS)) begin
            ancount_nxt = {acc_r[7:0], in_byte};
          end
          if (pos_r >= 17'(dmfp_pkg::LAST_HDR_POS)) begin
            phase_nxt   = dmfp_pkg::PH_NAME;
            label_nxt   = '0;
            started_nxt = 1'b0;
          end
        end
        dmfp_pkg::PH_NAME: begin
          if (in_byte == 8'h00) begin
            if (!mode_r || ancount_r != '0) begin
              phase_nxt = dmfp_pkg::PH_QTYPE;
              acc_nxt   = '0;
              cnt_nxt   = '0;
            end else begin
              phase_nxt = dmfp_pkg::PH_IDLE;
            end
          end else if (label_r == '0) begin
            label_nxt   = in_byte;
            started_nxt = 1'b1;
          end else begin
            label_nxt = label_r - 8'd1;
          end
        end
        dmfp_pkg::PH_ADDR: begin
          label_nxt = label_r - 8'd1;
          if (label_r == 8'd1) begin
            phase_nxt = dmfp_pkg::PH_IDLE;
          end
        end
        dmfp_pkg::PH_QTYPE, dmfp_pkg::PH_QCLASS, dmfp_pkg::PH_PTR, dmfp_pkg::PH_TYPE,
        dmfp_pkg::PH_CLASS, dmfp_pkg::PH_TTL, dmfp_pkg::PH_RDLEN: begin
          acc_nxt = acc_shift;
          cnt_nxt = cnt_inc;
          if (field_done) begin
            acc_nxt = '0;
            cnt_nxt = '0;
            unique case (phase_r)
              dmfp_pkg::PH_QTYPE:  phase_nxt = dmfp_pkg::PH_QCLASS;
              dmfp_pkg::PH_QCLASS: phase_nxt = mode_r ? dmfp_pkg::PH_PTR : dmfp_pkg::PH_IDLE;
              dmfp_pkg::PH_PTR:    phase_nxt = dmfp_pkg::PH_TYPE;
              dmfp_pkg::PH_TYPE: begin
                phase_nxt = (acc_shift == {16'h0, wanted_r}) ? dmfp_pkg::PH_CLASS
                                                             : dmfp_pkg::PH_IDLE;
              end
              dmfp_pkg::PH_CLASS:  phase_nxt = dmfp_pkg::PH_TTL;
              dmfp_pkg::PH_TTL:    phase_nxt = dmfp_pkg::PH_RDLEN;
              default: begin
                phase_nxt = dmfp_pkg::PH_ADDR;
                label_nxt = 8'(dmfp_pkg::ADDR_BYTES);
              end
            endcase
          end
        end
        default: ;
      endcase
      // message end returns to the length prefix
      if (final_byte) begin
        pos_nxt     = '0;
        len_nxt     = '0;
        phase_nxt   = dmfp_pkg::PH_PREFIX;
        label_nxt   = '0;
        started_nxt = 1'b0;
        acc_nxt     = '0;
        cnt_nxt     = '0;
        ancount_nxt = '0;
      end else begin
        pos_nxt = pos_r + 17'd1;
      end
    end
  end

  // result of the current byte
  always_comb begin
    have  = 1'b0;
    kind  = dmfp_pkg::K_CHAR;
    value = '0;
    unique case (phase_r)
      dmfp_pkg::PH_HEADER: begin
        if (pos_r == 17'(dmfp_pkg::ANC_LO_POS)) begin
          have  = 1'b1;
          kind  = dmfp_pkg::K_ANCOUNT;
          value = {16'h0, acc_r[7:0], in_byte};
        end
      end
      dmfp_pkg::PH_NAME: begin
        if (in_byte != 8'h00) begin
          if (label_r == '0) begin
            have  = started_r;
            value = {24'h0, dmfp_pkg::DOT_CHAR};
          end else begin
            have  = 1'b1;
            value = {24'h0, in_byte};
          end
        end
      end
      dmfp_pkg::PH_ADDR: begin
        have  = 1'b1;
        kind  = dmfp_pkg::K_ADDR;
        value = {24'h0, in_byte};
      end
      dmfp_pkg::PH_QTYPE, dmfp_pkg::PH_QCLASS, dmfp_pkg::PH_PTR, dmfp_pkg::PH_TYPE,
      dmfp_pkg::PH_CLASS, dmfp_pkg::PH_TTL, dmfp_pkg::PH_RDLEN: begin
        value = acc_shift;
        if (field_done) begin
          unique case (phase_r)
            dmfp_pkg::PH_QTYPE: begin
              have = !mode_r;
              kind = dmfp_pkg::K_QTYPE;
            end
            dmfp_pkg::PH_QCLASS: begin
              have = !mode_r;
              kind = dmfp_pkg::K_QCLASS;
            end
            dmfp_pkg::PH_PTR: have = 1'b0;
            dmfp_pkg::PH_TYPE: begin
              have = 1'b1;
              kind = dmfp_pkg::K_TYPE;
            end
            dmfp_pkg::PH_CLASS: begin
              have = 1'b1;
              kind = dmfp_pkg::K_CLASS;
            end
            dmfp_pkg::PH_TTL: begin
              have = 1'b1;
              kind = dmfp_pkg::K_TTL;
            end
            default: begin
              have = 1'b1;
              kind = dmfp_pkg::K_RDLEN;
            end
          endcase
        end
      end
      default: ;
    endcase
    // final byte always yields a result
    if (final_byte && !have) begin
      have  = 1'b1;
      kind  = dmfp_pkg::K_END;
      value = '0;
    end
  end

  assign push.valid     = accept && have;
  assign push.res.kind  = kind;
  assign push.res.value = value;
  assign push.res.last  = final_byte;

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      len_r     <= '0;
      phase_r   <= dmfp_pkg::PH_PREFIX;
      label_r   <= '0;
      started_r <= 1'b0;
      acc_r     <= '0;
      cnt_r     <= '0;
      ancount_r <= '0;
      mode_r    <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      phase_r   <= phase_nxt;
      label_r   <= label_nxt;
      started_r <= started_nxt;
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      ancount_r <= ancount_nxt;
      mode_r    <= mode_nxt;
    end
  end

  // wanted answer type register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= dmfp_pkg::WANTED_RST;
    end else if (cfg_tvalid) begin
      wanted_r <= cfg_value;
    end
  end

endmodule

>>> sv/dmfp_queue.sv
module dmfp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  dmfp_pkg::push_t  push,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output dmfp_pkg::res_t   head
);

  dmfp_pkg::res_t               mem_r [dmfp_pkg::QDEPTH];
  logic [dmfp_pkg::QAW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [dmfp_pkg::QAW:0]       count_r, count_nxt;
  logic                         do_pop;

  assign full      = (count_r == (dmfp_pkg::QAW+1)'(dmfp_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  // occupancy update
  always_comb begin
    count_nxt = count_r;
    if (push.valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.res;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

>>> sv/dmfp_back.sv
module dmfp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  dmfp_pkg::res_t   q_head,
  input  logic             out_tready,
  output logic             q_pop,
  output logic             out_tvalid,
  output dmfp_pkg::res_t   out_res
);

  logic           valid_r;
  dmfp_pkg::res_t res_r;

  // refill the output register when it is empty or being taken
  assign q_pop      = q_not_empty && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_tready) begin
      valid_r <= q_not_empty;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= q_head;
    end
  end

endmodule

>>> sv/dns_message_field_parser.sv
// channel | dir | handshake              | payload
// in      | in  | in_tvalid / in_tready  | tdata: msg_byte[7:0]; tuser: mode[0]
// out     | out | out_tvalid / out_tready| tdata: value[31:0]; tuser: kind[3:0]; tlast: last
// cfg     | in  | cfg_tvalid / cfg_tready| tdata: wanted_type[15:0]
//
// one byte is accepted per cycle while the result queue is not full; each result passes
// through a four-entry result queue and an output register before it reaches out_tdata
// the parser state updates in the cycle of the transfer, so bytes flow back to back
// in_tready drops only while the result queue is full; cfg_tready is always high
// rst_n is synchronous: the parser returns to the length prefix, wanted_type to 28
module dns_message_field_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // msg_byte[7:0]
  input  logic [0:0]  in_tuser,   // mode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value[31:0]
  output logic [3:0]  out_tuser,  // kind[3:0]
  output logic        out_tlast,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [15:0] cfg_tdata   // wanted_type[15:0]
);

  dmfp_pkg::push_t push;
  dmfp_pkg::res_t  q_head;
  dmfp_pkg::res_t  out_res;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;

  assign cfg_tready = 1'b1;

  // parser front end
  dmfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_byte    (in_tdata),
    .in_mode    (in_tuser[0]),
    .q_full     (q_full),
    .cfg_tvalid (cfg_tvalid),
    .cfg_value  (cfg_tdata),
    .in_tready  (in_tready),
    .push       (push)
  );

  // result queue
  dmfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // output stage
  dmfp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .out_tready  (out_tready),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_res     (out_res)
  );

  assign out_tdata = out_res.value;
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

>>> tb/tb_dns_message_field_parser.sv
module tb_dns_message_field_parser;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned SETTLE     = 8;
  localparam int unsigned PHASE_ITEMS = 130;
  localparam int unsigned NDIR       = 17;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_tvalid;
  logic        cfg_tready;
  logic [15:0] cfg_tdata;

  dns_message_field_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // msg_byte[7:0]
    .in_tuser   (in_tuser),   // mode[0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // value[31:0]
    .out_tuser  (out_tuser),  // kind[3:0]
    .out_tlast  (out_tlast),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)   // wanted_type[15:0]
  );

  always #5 clk = ~clk;

  // one row of the directed byte table
  typedef struct {
    logic [7:0]      b;
    logic            m;
    bit              typed;
    dmfp_pkg::kind_t kind;
    logic [31:0]     value;
    logic            last;
  } byte_row_t;

  // fields the block should still deliver, oldest first
  dmfp_pkg::res_t pending_fields[$];
  int unsigned    fail_count = 0;
  bit             no_idle = 1'b0;

  // parser shadow state
  logic [16:0]      pr_pos;
  logic [15:0]      pr_len;
  dmfp_pkg::phase_t pr_phase;
  logic [7:0]       pr_label;
  bit               pr_started;
  logic [31:0]      pr_acc;
  logic [2:0]       pr_cnt;
  logic [15:0]      pr_ancount;
  logic             pr_mode;
  logic [15:0]      pr_wanted;

  task automatic clear_parse();
    pr_pos     = '0;
    pr_len     = '0;
    pr_phase   = dmfp_pkg::PH_PREFIX;
    pr_label   = '0;
    pr_started = 1'b0;
    pr_acc     = '0;
    pr_cnt     = '0;
    pr_ancount = '0;
  endtask

  task automatic start_field(input dmfp_pkg::phase_t p);
    pr_phase = p;
    pr_acc   = '0;
    pr_cnt   = '0;
  endtask

  // advance the shadow parser by one byte, give the field it yields if any
  task automatic parse_byte(input logic [7:0] b, input logic m, output bit got,
                            output dmfp_pkg::res_t r);
    logic [16:0] pos;
    logic [31:0] v;
    logic [2:0]  need;
    bit          fin;
    pos = pr_pos;
    got = 1'b0;
    r.kind  = dmfp_pkg::K_END;
    r.value = '0;
    r.last  = 1'b0;
    if (pr_phase == dmfp_pkg::PH_PREFIX && pos == 17'd0) begin
      pr_mode = m;
      pr_len  = {b, 8'h00};
      pr_pos  = 17'd1;
      return;
    end
    case (pr_phase)
      dmfp_pkg::PH_PREFIX: begin
        pr_len   = pr_len | {8'h00, b};
        pr_phase = dmfp_pkg::PH_HEADER;
      end
      dmfp_pkg::PH_HEADER: begin
        if (pos == 17'(dmfp_pkg::ANC_HI_POS)) begin
          pr_acc = {24'd0, b};
        end else if (pos == 17'(dmfp_pkg::ANC_LO_POS)) begin
          pr_ancount = {pr_acc[7:0], b};
          got = 1'b1; r.kind = dmfp_pkg::K_ANCOUNT; r.value = {16'd0, pr_ancount};
        end
        if (pos >= 17'(dmfp_pkg::LAST_HDR_POS)) begin
          pr_phase   = dmfp_pkg::PH_NAME;
          pr_label   = '0;
          pr_started = 1'b0;
        end
      end
      dmfp_pkg::PH_NAME: begin
        if (b == 8'd0) begin
          // a zero byte always ends the name
          if (!pr_mode || pr_ancount != 16'd0) start_field(dmfp_pkg::PH_QTYPE);
          else pr_phase = dmfp_pkg::PH_IDLE;
        end else if (pr_label == 8'd0) begin
          pr_label = b;
          if (pr_started) begin
            got = 1'b1; r.kind = dmfp_pkg::K_CHAR; r.value = {24'd0, dmfp_pkg::DOT_CHAR};
          end
          pr_started = 1'b1;
        end else begin
          got = 1'b1; r.kind = dmfp_pkg::K_CHAR; r.value = {24'd0, b};
          pr_label = pr_label - 8'd1;
        end
      end
      dmfp_pkg::PH_ADDR: begin
        got = 1'b1; r.kind = dmfp_pkg::K_ADDR; r.value = {24'd0, b};
        pr_label = pr_label - 8'd1;
        if (pr_label == 8'd0) pr_phase = dmfp_pkg::PH_IDLE;
      end
      dmfp_pkg::PH_QTYPE, dmfp_pkg::PH_QCLASS, dmfp_pkg::PH_PTR, dmfp_pkg::PH_TYPE,
      dmfp_pkg::PH_CLASS, dmfp_pkg::PH_TTL, dmfp_pkg::PH_RDLEN: begin
        need   = (pr_phase == dmfp_pkg::PH_TTL) ? 3'd4 : 3'd2;
        pr_acc = {pr_acc[23:0], b};
        pr_cnt = pr_cnt + 3'd1;
        if (pr_cnt >= need) begin
          v = pr_acc;
          case (pr_phase)
            dmfp_pkg::PH_QTYPE: begin
              if (!pr_mode) begin
                got = 1'b1; r.kind = dmfp_pkg::K_QTYPE; r.value = v;
              end
              start_field(dmfp_pkg::PH_QCLASS);
            end
            dmfp_pkg::PH_QCLASS: begin
              if (!pr_mode) begin
                got = 1'b1; r.kind = dmfp_pkg::K_QCLASS; r.value = v;
                pr_phase = dmfp_pkg::PH_IDLE;
              end else begin
                start_field(dmfp_pkg::PH_PTR);
              end
            end
            dmfp_pkg::PH_PTR: start_field(dmfp_pkg::PH_TYPE);
            dmfp_pkg::PH_TYPE: begin
              got = 1'b1; r.kind = dmfp_pkg::K_TYPE; r.value = v;
              if (v == {16'd0, pr_wanted}) start_field(dmfp_pkg::PH_CLASS);
              else pr_phase = dmfp_pkg::PH_IDLE;
            end
            dmfp_pkg::PH_CLASS: begin
              got = 1'b1; r.kind = dmfp_pkg::K_CLASS; r.value = v;
              start_field(dmfp_pkg::PH_TTL);
            end
            dmfp_pkg::PH_TTL: begin
              got = 1'b1; r.kind = dmfp_pkg::K_TTL; r.value = v;
              start_field(dmfp_pkg::PH_RDLEN);
            end
            default: begin
              got = 1'b1; r.kind = dmfp_pkg::K_RDLEN; r.value = v;
              pr_phase = dmfp_pkg::PH_ADDR;
              pr_label = 8'(dmfp_pkg::ADDR_BYTES);
            end
          endcase
        end
      end
      default: ;
    endcase
    // the byte that completes the framed length closes the message
    fin = (pos == {1'b0, pr_len} + 17'd1);
    if (fin) begin
      if (!got) begin
        got = 1'b1; r.kind = dmfp_pkg::K_END; r.value = '0;
      end
      clear_parse();
    end else begin
      pr_pos = pos + 17'd1;
    end
    r.last = fin;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one byte transfer on the input channel; gives back the shadow result
  task automatic push_byte(input logic [7:0] b, input logic m, output bit got,
                           output dmfp_pkg::res_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_byte(b, m, got, r);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic m);
    bit             got;
    dmfp_pkg::res_t r;
    push_byte(b, m, got, r);
    if (got) pending_fields.push_back(r);
  endtask

  // let outstanding fields drain and the pipeline settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_wanted(input logic [15:0] v);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= v;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    cfg_tvalid <= 1'b0;
    pr_wanted = v;
  endtask

  // build one message body: mostly well formed, some cut short, some noise
  task automatic make_message(output logic m, ref logic [7:0] body[$], input bit pad);
    int unsigned nlab;
    int unsigned llen;
    int unsigned cut;
    logic [15:0] anc;
    logic [15:0] rtype;
    body = {};
    m = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(0, 40)) body.push_back(8'($urandom));
      return;
    end
    for (int i = 0; i < 12; i++) body.push_back(8'($urandom));
    if (m) begin
      case ($urandom_range(0, 3))
        0: anc = 16'd0;
        1: anc = 16'($urandom);
        default: anc = 16'd1;
      endcase
      body[6] = anc[15:8];
      body[7] = anc[7:0];
    end
    // question name, with a rare stray zero inside a label
    nlab = $urandom_range(0, 4);
    for (int l = 0; l < nlab; l++) begin
      llen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8);
      body.push_back(8'(llen));
      for (int c = 0; c < llen; c++)
        body.push_back(($urandom_range(0, 49) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
    end
    body.push_back(8'd0);
    repeat (4) body.push_back(8'($urandom));
    if (m) begin
      body.push_back(8'hc0);
      body.push_back(8'h0c);
      rtype = ($urandom_range(0, 2) != 0) ? pr_wanted : 16'($urandom);
      body.push_back(rtype[15:8]);
      body.push_back(rtype[7:0]);
      repeat (6) body.push_back(8'($urandom));
      body.push_back(8'h00);
      body.push_back(8'h10);
      repeat (dmfp_pkg::ADDR_BYTES) body.push_back(8'($urandom));
    end
    repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
    if (pad) repeat (260) body.push_back(8'($urandom));
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(0, body.size());
      while (body.size() > cut) void'(body.pop_back());
    end
  endtask

  // result side: random back-pressure and in-order field check
  initial begin
    int unsigned    stall_left;
    dmfp_pkg::res_t want;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (pending_fields.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected field: kind %0d value %h last %b",
                     out_tuser, out_tdata, out_tlast);
        end else begin
          want = pending_fields.pop_front();
          if (out_tuser !== want.kind || out_tdata !== want.value ||
              out_tlast !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: expected kind %0d value %h last %b, ",
                        "got kind %0d value %h last %b"},
                       want.kind, want.value, want.last, out_tuser, out_tdata, out_tlast);
          end
        end
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_tvalid && cfg_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // stimulus
  initial begin
    byte_row_t      steer[NDIR];
    logic [15:0]    wanted_plan[6];
    logic [7:0]     body[$];
    logic [15:0]    len;
    logic           m;
    int unsigned    sent;
    bit             got;
    dmfp_pkg::res_t r;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    cfg_tvalid <= 1'b0;
    cfg_tdata  <= '0;

    // zero length request; all-ones header cut short; ancount on the final byte
    steer = '{
      '{8'h00, 1'b0, 1'b0, dmfp_pkg::K_END,     32'd0,        1'b0},
      '{8'h00, 1'b1, 1'b1, dmfp_pkg::K_END,     32'd0,        1'b1},
      '{8'h00, 1'b1, 1'b0, dmfp_pkg::K_END,     32'd0,        1'b0},
      '{8'h03, 1'b0, 1'b0, dmfp_pkg::K_END,     32'd0,        1'b0},
      '{8'hff, 1'b0, 1'b0, dmfp_pkg::K_END,     32'd0,        1'b0},
      '{8'hff, 1'b1, 1'b0, dmfp_pkg::K_END,     32'd0,        1'b0},
      '{8'hff, 1'b0, 1'b1, dmfp_pkg::K_END,     32'd0,        1'b1},
      '{8'h00, 1'b0, 1'b0, dmfp_pkg::K_END,     32'd0,        1'b0},
      '{8'h08, 1'b1, 1'b0, dmfp_pkg::K_END,     32'd0,        1'b0},
      '{8'h12, 1'b0, 1'b0, dmfp_pkg::K_END,     32'd0,        1'b0},
      '{8'h34, 1'b1, 1'b0, dmfp_pkg::K_END,     32'd0,        1'b0},
      '{8'hff, 1'b0, 1'b0, dmfp_pkg::K_END,     32'd0,        1'b0},
      '{8'h00, 1'b1, 1'b0, dmfp_pkg::K_END,     32'd0,        1'b0},
      '{8'h80, 1'b0, 1'b0, dmfp_pkg::K_END,     32'd0,        1'b0},
      '{8'h01, 1'b1, 1'b0, dmfp_pkg::K_END,     32'd0,        1'b0},
      '{8'hab, 1'b0, 1'b0, dmfp_pkg::K_END,     32'd0,        1'b0},
      '{8'hcd, 1'b1, 1'b1, dmfp_pkg::K_ANCOUNT, 32'h0000abcd, 1'b1}
    };
    wanted_plan = '{dmfp_pkg::WANTED_RST, 16'hffff, 16'h0000, 16'h0001, 16'($urandom),
                    dmfp_pkg::WANTED_RST};

    pr_wanted = dmfp_pkg::WANTED_RST;
    pr_mode   = 1'b0;
    clear_parse();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NDIR; i++) begin
      no_idle = (i < 7);
      push_byte(steer[i].b, steer[i].m, got, r);
      if (steer[i].typed) begin
        r.kind  = steer[i].kind;
        r.value = steer[i].value;
        r.last  = steer[i].last;
        pending_fields.push_back(r);
      end else if (got) begin
        pending_fields.push_back(r);
      end
    end

    // random messages, one wanted_type setting per stretch
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_wanted(wanted_plan[ph]);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        no_idle = ($urandom_range(0, 3) == 0);
        make_message(m, body, ph == 3 && sent == 0);
        len = 16'(body.size());
        send_byte(len[15:8], m);
        send_byte(len[7:0], 1'($urandom));
        foreach (body[i]) send_byte(body[i], 1'($urandom));
        sent += body.size() + 2;
      end
    end

    wait_drained();
    if (fail_count == 0 && pending_fields.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/dmfp_pkg.sv
sv/dmfp_front.sv
sv/dmfp_queue.sv
sv/dmfp_back.sv
sv/dns_message_field_parser.sv
tb/tb_dns_message_field_parser.sv
